// File: src/ofwm_pkg.sv
// Shared widths, register codes and reset values for the omni four-wheel mixer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package ofwm_pkg;

    localparam int COMMAND_WIDTH_DEF = 16;
    localparam int GAIN_W            = 16;
    localparam int MAXV_W            = 15;
    localparam int VEL_W             = 16;
    localparam int GAIN_FRAC         = 4;
    localparam int CFG_DATA_W        = 16;
    localparam int CFG_IDX_W         = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_VELOCITY_GAIN = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_VELOCITY  = 1'd1;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd51338;
    localparam logic [MAXV_W-1:0] MAXV_RESET = 15'd512;

    typedef struct packed {
        logic [GAIN_W-1:0] gain;
        logic [MAXV_W-1:0] max_vel;
    } ofwm_cfg_t;

    localparam ofwm_cfg_t CFG_RESET = '{gain: GAIN_RESET, max_vel: MAXV_RESET};

endpackage

// File: src/ofwm_sqrt.sv
// Pipelined integer square root, one result bit per register stage.
// Carries a side word alongside the radicand; depends on ofwm_pkg.
`timescale 1ns / 1ps

module ofwm_sqrt
    import ofwm_pkg::*;
#(
    parameter int ROOT_W = COMMAND_WIDTH_DEF,
    parameter int SIDE_W = 1
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  rad_valid,
    input  logic [2*ROOT_W-1:0]   radicand,
    input  logic [SIDE_W-1:0]     rad_side,
    output logic                  root_valid,
    output logic [ROOT_W-1:0]     root,
    output logic [SIDE_W-1:0]     root_side
);

    localparam int RAD_W = 2 * ROOT_W;

    logic [RAD_W-1:0]  rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    logic [SIDE_W-1:0] side_reg [ROOT_W];
    logic              vld_reg  [ROOT_W];

    genvar k;
    generate
        for (k = 0; k < ROOT_W; k++)
        begin : g_stage
            localparam int BIT = ROOT_W - 1 - k;

            logic [RAD_W-1:0]  rem_in;
            logic [ROOT_W-1:0] root_in;
            logic [SIDE_W-1:0] side_in;
            logic              vld_in;
            logic [RAD_W-1:0]  trial;
            logic [RAD_W-1:0]  rem_next;
            logic [ROOT_W-1:0] root_next;

            if (k == 0)
            begin : g_first
                assign rem_in  = radicand;
                assign root_in = '0;
                assign side_in = rad_side;
                assign vld_in  = rad_valid;
            end
            else
            begin : g_rest
                assign rem_in  = rem_reg[k-1];
                assign root_in = root_reg[k-1];
                assign side_in = side_reg[k-1];
                assign vld_in  = vld_reg[k-1];
            end

            always_comb
            begin
                trial = (RAD_W'(root_in) << (BIT + 1)) + (RAD_W'(1) << (2 * BIT));
                if (rem_in >= trial)
                begin
                    rem_next  = rem_in - trial;
                    root_next = root_in | (ROOT_W'(1) << BIT);
                end
                else
                begin
                    rem_next  = rem_in;
                    root_next = root_in;
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[k] <= 1'b0;
                end
                else
                begin
                    vld_reg[k] <= vld_in;
                end
            end

            always_ff @(posedge clk)
            begin
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                side_reg[k] <= side_in;
            end
        end
    endgenerate

    assign root_valid = vld_reg[ROOT_W-1];
    assign root       = root_reg[ROOT_W-1];
    assign root_side  = side_reg[ROOT_W-1];

endmodule

// File: src/ofwm_wheel.sv
// One wheel channel: rotation mix, unit clamp, gain multiply, velocity saturation.
// Three register stages; depends on ofwm_pkg for widths and the config struct.
`timescale 1ns / 1ps

module ofwm_wheel
    import ofwm_pkg::*;
#(
    parameter int CMD_W   = COMMAND_WIDTH_DEF,
    parameter bit ADD_ROT = 1'b1,
    parameter bit FLIP    = 1'b1
)
(
    input  logic                    clk,
    input  ofwm_cfg_t               cfg,
    input  logic signed [CMD_W:0]   trans,
    input  logic signed [CMD_W-1:0] rot,
    output logic signed [VEL_W-1:0] vel
);

    localparam int P_W   = CMD_W + 2;
    localparam int MAG_W = CMD_W - 1;
    localparam int PRD_W = MAG_W + GAIN_W;
    localparam int SHIFT = CMD_W - 2 + GAIN_FRAC;
    localparam int SH_W  = PRD_W - SHIFT;

    localparam logic signed [P_W-1:0] P_ONE     = {3'b000, 1'b1, {(CMD_W-2){1'b0}}};
    localparam logic signed [P_W-1:0] P_NEG_ONE = -P_ONE;

    logic signed [P_W-1:0]   p_raw;
    logic signed [P_W-1:0]   p_clamp;
    logic signed [P_W-1:0]   p_abs;
    logic [MAG_W-1:0]        mag_next;
    logic                    neg_next;
    logic [MAG_W-1:0]        mag_reg;
    logic                    neg_reg;
    logic [PRD_W-1:0]        prod_next;
    logic [PRD_W-1:0]        prod_reg;
    logic                    neg2_reg;
    logic [SH_W-1:0]         scaled;
    logic [MAXV_W-1:0]       q;
    logic signed [VEL_W-1:0] vel_next;
    logic signed [VEL_W-1:0] vel_reg;

    always_comb
    begin
        if (ADD_ROT)
        begin
            p_raw = P_W'(rot) + P_W'(trans);
        end
        else
        begin
            p_raw = P_W'(trans) - P_W'(rot);
        end

        if (p_raw > P_ONE)
        begin
            p_clamp = P_ONE;
        end
        else if (p_raw < P_NEG_ONE)
        begin
            p_clamp = P_NEG_ONE;
        end
        else
        begin
            p_clamp = p_raw;
        end

        p_abs    = p_clamp[P_W-1] ? -p_clamp : p_clamp;
        mag_next = p_abs[MAG_W-1:0];
        neg_next = FLIP ? (p_clamp > 0) : p_clamp[P_W-1];
    end

    assign prod_next = mag_reg * cfg.gain;

    always_comb
    begin
        scaled = prod_reg[PRD_W-1:SHIFT];
        if (MAXV_W'(scaled) > cfg.max_vel)
        begin
            q = cfg.max_vel;
        end
        else
        begin
            q = MAXV_W'(scaled);
        end
        vel_next = neg2_reg ? -$signed(VEL_W'(q)) : $signed(VEL_W'(q));
    end

    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_next;
        neg_reg  <= neg_next;
        prod_reg <= prod_next;
        neg2_reg <= neg_reg;
        vel_reg  <= vel_next;
    end

    assign vel = vel_reg;

endmodule

// File: src/omni_four_wheel_mixer.sv
// Four-wheel X-drive mixer: strafe, forward and rotate command in, four wheel velocities out.
// Throughput one transaction per cycle; the depth is set by the one-bit-per-stage square root.
// busy stays low; results cannot be held off. Reset clears the valid bits and loads the
// register defaults. Depends on ofwm_pkg, ofwm_sqrt and ofwm_wheel.
`timescale 1ns / 1ps

module omni_four_wheel_mixer
    import ofwm_pkg::*;
#(
    parameter int COMMAND_WIDTH = COMMAND_WIDTH_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic signed [COMMAND_WIDTH-1:0] strafe_cmd,
    input  logic signed [COMMAND_WIDTH-1:0] forward_cmd,
    input  logic signed [COMMAND_WIDTH-1:0] rotate_cmd,
    input  logic                            cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0]           cfg_wdata,
    output logic                            done,
    output logic signed [VEL_W-1:0]         wheel_a_vel,
    output logic signed [VEL_W-1:0]         wheel_b_vel,
    output logic signed [VEL_W-1:0]         wheel_c_vel,
    output logic signed [VEL_W-1:0]         wheel_d_vel
);

    localparam int W            = COMMAND_WIDTH;
    localparam int RAD_W        = 2 * W;
    localparam int SIDE_W       = 3 * W + 2;
    localparam int WHEEL_STAGES = 3;
    localparam int LATENCY      = W + 6;

    ofwm_cfg_t cfg_reg;
    ofwm_cfg_t cfg_next;

    logic                    accept;
    logic signed [RAD_W-1:0] xx_next;
    logic signed [RAD_W-1:0] yy_next;
    logic signed [W:0]       d_next;
    logic signed [W:0]       s_next;

    logic                    s1_vld_reg;
    logic [RAD_W-1:0]        xx_reg;
    logic [RAD_W-1:0]        yy_reg;
    logic signed [W:0]       d_reg;
    logic signed [W:0]       s_reg;
    logic signed [W-1:0]     r_reg;

    logic                    s2_vld_reg;
    logic [RAD_W-1:0]        sq_reg;
    logic [SIDE_W-1:0]       s2_side_reg;

    logic                    root_vld;
    logic [W-1:0]            root_n;
    logic [SIDE_W-1:0]       root_side;
    logic signed [W:0]       d_rt;
    logic signed [W:0]       s_rt;
    logic signed [W-1:0]     r_rt;
    logic signed [W:0]       n_pos;
    logic signed [W:0]       n_neg;
    logic signed [W:0]       tac_next;
    logic signed [W:0]       tbd_next;

    logic                    s3_vld_reg;
    logic signed [W:0]       tac_reg;
    logic signed [W:0]       tbd_reg;
    logic signed [W-1:0]     r3_reg;

    logic [WHEEL_STAGES-1:0] wv_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_VELOCITY_GAIN: cfg_next.gain    = cfg_wdata[GAIN_W-1:0];
                CFG_MAX_VELOCITY:  cfg_next.max_vel = cfg_wdata[MAXV_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    assign xx_next = strafe_cmd * strafe_cmd;
    assign yy_next = forward_cmd * forward_cmd;
    assign d_next  = (W+1)'(forward_cmd) - (W+1)'(strafe_cmd);
    assign s_next  = (W+1)'(forward_cmd) + (W+1)'(strafe_cmd);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg    <= CFG_RESET;
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            wv_reg     <= '0;
        end
        else
        begin
            cfg_reg    <= cfg_next;
            s1_vld_reg <= accept;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= root_vld;
            wv_reg     <= {wv_reg[WHEEL_STAGES-2:0], s3_vld_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        xx_reg      <= $unsigned(xx_next);
        yy_reg      <= $unsigned(yy_next);
        d_reg       <= d_next;
        s_reg       <= s_next;
        r_reg       <= rotate_cmd;
        sq_reg      <= xx_reg + yy_reg;
        s2_side_reg <= {d_reg, s_reg, r_reg};
        tac_reg     <= tac_next;
        tbd_reg     <= tbd_next;
        r3_reg      <= r_rt;
    end

    ofwm_sqrt #(
        .ROOT_W (W),
        .SIDE_W (SIDE_W)
    ) u_sqrt (
        .clk        (clk),
        .rst_n      (rst_n),
        .rad_valid  (s2_vld_reg),
        .radicand   (sq_reg),
        .rad_side   (s2_side_reg),
        .root_valid (root_vld),
        .root       (root_n),
        .root_side  (root_side)
    );

    always_comb
    begin
        {d_rt, s_rt, r_rt} = root_side;
        n_pos = $signed({1'b0, root_n});
        n_neg = -n_pos;

        if (d_rt > n_pos)
        begin
            tac_next = n_pos;
        end
        else if (d_rt < n_neg)
        begin
            tac_next = n_neg;
        end
        else
        begin
            tac_next = d_rt;
        end

        if (s_rt > n_pos)
        begin
            tbd_next = n_pos;
        end
        else if (s_rt < n_neg)
        begin
            tbd_next = n_neg;
        end
        else
        begin
            tbd_next = s_rt;
        end
    end

    ofwm_wheel #(.CMD_W(W), .ADD_ROT(1'b1), .FLIP(1'b1)) u_wheel_a (
        .clk   (clk),
        .cfg   (cfg_reg),
        .trans (tac_reg),
        .rot   (r3_reg),
        .vel   (wheel_a_vel)
    );

    ofwm_wheel #(.CMD_W(W), .ADD_ROT(1'b1), .FLIP(1'b1)) u_wheel_b (
        .clk   (clk),
        .cfg   (cfg_reg),
        .trans (tbd_reg),
        .rot   (r3_reg),
        .vel   (wheel_b_vel)
    );

    ofwm_wheel #(.CMD_W(W), .ADD_ROT(1'b0), .FLIP(1'b0)) u_wheel_c (
        .clk   (clk),
        .cfg   (cfg_reg),
        .trans (tac_reg),
        .rot   (r3_reg),
        .vel   (wheel_c_vel)
    );

    ofwm_wheel #(.CMD_W(W), .ADD_ROT(1'b0), .FLIP(1'b0)) u_wheel_d (
        .clk   (clk),
        .cfg   (cfg_reg),
        .trans (tbd_reg),
        .rot   (r3_reg),
        .vel   (wheel_d_vel)
    );

    assign done = wv_reg[WHEEL_STAGES-1];

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LATENCY done)
        else $error("accepted transaction did not complete on time");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LATENCY))
        else $error("done without a matching accepted transaction");

    a_limit_a: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (wheel_a_vel <= $signed({2'b00, cfg_reg.max_vel})
                  && wheel_a_vel >= -$signed({2'b00, cfg_reg.max_vel})))
        else $error("wheel A velocity beyond limit");

    a_limit_d: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (wheel_d_vel <= $signed({2'b00, cfg_reg.max_vel})
                  && wheel_d_vel >= -$signed({2'b00, cfg_reg.max_vel})))
        else $error("wheel D velocity beyond limit");

    a_zero_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (done && cfg_reg.max_vel == '0) |-> (wheel_a_vel == '0 && wheel_b_vel == '0
                                             && wheel_c_vel == '0 && wheel_d_vel == '0))
        else $error("nonzero velocity with zero limit");

endmodule
